// File: rtl/core/sum_of_prime_factors_defines.svh
// assertion macros for the sum of prime factors block
// plain text macros, no dependencies
`ifndef SUM_OF_PRIME_FACTORS_DEFINES_SVH
`define SUM_OF_PRIME_FACTORS_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SPF_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SPF_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/spf_pkg.sv
// shared types, constants and microcode rom for sum_of_prime_factors
// no dependencies
`timescale 1ns / 1ps

package spf_pkg;

    localparam int IN_W  = 16;
    localparam int OUT_W = 16;
    localparam int PC_W  = 4;

    // step addresses; the wait step sits at the top so pc + 1 wraps to the first step
    localparam logic [PC_W-1:0] A_SMALL = 4'd0;
    localparam logic [PC_W-1:0] A_SQ    = 4'd1;
    localparam logic [PC_W-1:0] A_TEST  = 4'd2;
    localparam logic [PC_W-1:0] A_STEP  = 4'd3;
    localparam logic [PC_W-1:0] A_CHK   = 4'd4;
    localparam logic [PC_W-1:0] A_INC   = 4'd5;
    localparam logic [PC_W-1:0] A_TAIL  = 4'd6;
    localparam logic [PC_W-1:0] A_DONE  = 4'd7;
    localparam logic [PC_W-1:0] A_WAIT  = 4'd15;

    // jump conditions
    localparam logic [2:0] C_NEVER     = 3'd0;
    localparam logic [2:0] C_ALWAYS    = 3'd1;
    localparam logic [2:0] C_NO_START  = 3'd2;
    localparam logic [2:0] C_REM_LT2   = 3'd3;
    localparam logic [2:0] C_SQ_GT_REM = 3'd4;
    localparam logic [2:0] C_DIV_BUSY  = 3'd5;
    localparam logic [2:0] C_REM_ZERO  = 3'd6;
    localparam logic [2:0] C_OUT_BUSY  = 3'd7;

    typedef struct packed {
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
        logic            ld_item;
        logic            sq_ld;
        logic            div_init;
        logic            div_step;
        logic            take_factor;
        logic            inc_div;
        logic            add_tail;
        logic            ld_out;
    } ucode_t;

    typedef struct packed {
        logic init;
        logic step;
    } div_ctl_t;

    typedef struct packed {
        logic last;
        logic rem_zero;
    } div_sts_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t uc;
        uc = '0;
        unique case (pc)
            A_WAIT:
            begin
                uc.ld_item = 1'b1;
                uc.cond    = C_NO_START;
                uc.target  = A_WAIT;
            end
            A_SMALL:
            begin
                uc.cond   = C_REM_LT2;
                uc.target = A_DONE;
            end
            A_SQ:
            begin
                uc.sq_ld = 1'b1;
                uc.cond  = C_NEVER;
            end
            A_TEST:
            begin
                uc.div_init = 1'b1;
                uc.cond     = C_SQ_GT_REM;
                uc.target   = A_TAIL;
            end
            A_STEP:
            begin
                uc.div_step = 1'b1;
                uc.cond     = C_DIV_BUSY;
                uc.target   = A_STEP;
            end
            A_CHK:
            begin
                uc.take_factor = 1'b1;
                uc.cond        = C_REM_ZERO;
                uc.target      = A_TEST;
            end
            A_INC:
            begin
                uc.inc_div = 1'b1;
                uc.cond    = C_ALWAYS;
                uc.target  = A_SQ;
            end
            A_TAIL:
            begin
                uc.add_tail = 1'b1;
                uc.cond     = C_NEVER;
            end
            A_DONE:
            begin
                uc.ld_out = 1'b1;
                uc.cond   = C_OUT_BUSY;
                uc.target = A_DONE;
            end
            default:
            begin
                uc.cond   = C_ALWAYS;
                uc.target = A_WAIT;
            end
        endcase
        return uc;
    endfunction

endpackage

// File: rtl/core/spf_divider.sv
// bit-serial restoring divider, one quotient bit per cycle while step is asserted
// depends on spf_pkg for the control and status structs
`timescale 1ns / 1ps

module spf_divider #(
    parameter int WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spf_pkg::div_ctl_t    ctl,
    input  logic [WIDTH-1:0]     dividend,
    input  logic [WIDTH-1:0]     divisor,
    output logic [WIDTH-1:0]     quotient,
    output spf_pkg::div_sts_t    sts
);

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0] pr_reg, pr_next;
    logic [WIDTH-1:0] q_reg, q_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;
    logic             fits;

    assign shifted = {pr_reg, q_reg[WIDTH-1]};
    assign diff    = shifted - {1'b0, divisor};
    assign fits    = !diff[WIDTH];

    always_comb
    begin
        pr_next  = pr_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (ctl.init)
        begin
            pr_next  = '0;
            q_next   = dividend;
            cnt_next = '0;
        end
        else if (ctl.step)
        begin
            pr_next  = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
            q_next   = {q_reg[WIDTH-2:0], fits};
            cnt_next = CW'(cnt_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        pr_reg <= pr_next;
        q_reg  <= q_next;
    end

    assign quotient     = q_reg;
    assign sts.last     = (cnt_reg == CW'(WIDTH - 1));
    assign sts.rem_zero = (pr_reg == '0);

endmodule

// File: rtl/core/sum_of_prime_factors.sv
// values below 2 go straight to the finishing step; otherwise each trial runs the bit-serial
// divider once, with trial divisors from 2 while their square does not exceed the remainder
// throughput: one item at a time; the next transfer is taken once the sequencer is back in wait
// a finished result waits in the output register while the next item is taken and worked on
// reset: asynchronous active low, sets the step counter to the wait step and clears the output valid flag
`timescale 1ns / 1ps
`include "sum_of_prime_factors_defines.svh"

module sum_of_prime_factors #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [spf_pkg::IN_W-1:0]   value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [spf_pkg::OUT_W-1:0]  factor_sum
);

    localparam int DW = VALUE_WIDTH;

    // sequencer state
    logic [spf_pkg::PC_W-1:0] pc_reg, pc_next;
    spf_pkg::ucode_t          ucw;
    logic                     cond_true;

    // datapath registers
    logic [DW-1:0]            rem_reg, rem_next;
    logic [DW-1:0]            sum_reg, sum_next;
    logic [DW-1:0]            div_reg, div_next;
    logic [2*DW-1:0]          sq_reg, sq_next;
    logic [spf_pkg::OUT_W-1:0] res_reg, res_next;
    logic                     out_valid_reg, out_valid_next;

    // divider link
    spf_pkg::div_ctl_t        div_ctl;
    spf_pkg::div_sts_t        div_sts;
    logic [DW-1:0]            quot;

    logic                     start;
    logic                     out_free;
    logic [spf_pkg::OUT_W-1:0] sum_sat;

    // control word for the current step
    assign ucw = spf_pkg::ucode_rom(pc_reg);

    // input transfer only in the wait step
    assign in_ready = (pc_reg == spf_pkg::A_WAIT);
    assign start    = in_valid && in_ready;

    // output register can take a new result when empty or being drained
    assign out_free = !out_valid_reg || out_ready;

    assign div_ctl.init = ucw.div_init;
    assign div_ctl.step = ucw.div_step;

    spf_divider #(
        .WIDTH (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (rem_reg),
        .divisor  (div_reg),
        .quotient (quot),
        .sts      (div_sts)
    );

    // clamp the sum to the output width; only reachable for wide configurations
    generate
        if (DW > spf_pkg::OUT_W)
        begin : g_sat
            assign sum_sat = (|sum_reg[DW-1:spf_pkg::OUT_W]) ? '1
                                                             : sum_reg[spf_pkg::OUT_W-1:0];
        end
        else
        begin : g_nosat
            assign sum_sat = spf_pkg::OUT_W'(sum_reg);
        end
    endgenerate

    // jump condition select
    always_comb
    begin
        unique case (ucw.cond)
            spf_pkg::C_NEVER:     cond_true = 1'b0;
            spf_pkg::C_ALWAYS:    cond_true = 1'b1;
            spf_pkg::C_NO_START:  cond_true = !start;
            spf_pkg::C_REM_LT2:   cond_true = (rem_reg < DW'(2));
            spf_pkg::C_SQ_GT_REM: cond_true = (sq_reg > (2*DW)'(rem_reg));
            spf_pkg::C_DIV_BUSY:  cond_true = !div_sts.last;
            spf_pkg::C_REM_ZERO:  cond_true = div_sts.rem_zero;
            spf_pkg::C_OUT_BUSY:  cond_true = !out_free;
            default:              cond_true = 1'b0;
        endcase
    end

    // step counter: jump on condition, otherwise fall through (wait wraps to the first step)
    assign pc_next = cond_true ? ucw.target : spf_pkg::PC_W'(pc_reg + 1'b1);

    // datapath updates driven by the control word
    always_comb
    begin
        rem_next       = rem_reg;
        sum_next       = sum_reg;
        div_next       = div_reg;
        sq_next        = sq_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;

        // result leaves on an output transfer
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // new item: bits above the working width are dropped
        if (ucw.ld_item && start)
        begin
            rem_next = DW'(value);
            sum_next = '0;
            div_next = DW'(2);
        end

        // square of the trial divisor, registered before the compare
        if (ucw.sq_ld)
        begin
            sq_next = (2*DW)'(div_reg) * (2*DW)'(div_reg);
        end

        // exact division: count the factor and keep the quotient
        if (ucw.take_factor && div_sts.rem_zero)
        begin
            sum_next = sum_reg + div_reg;
            rem_next = quot;
        end

        if (ucw.inc_div)
        begin
            div_next = div_reg + DW'(1);
        end

        // leftover above one is a prime factor
        if (ucw.add_tail && (rem_reg > DW'(1)))
        begin
            sum_next = sum_reg + rem_reg;
        end

        if (ucw.ld_out && out_free)
        begin
            res_next       = sum_sat;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= spf_pkg::A_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sum_reg <= sum_next;
        div_reg <= div_next;
        sq_reg  <= sq_next;
        res_reg <= res_next;
    end

    assign out_valid  = out_valid_reg;
    assign factor_sum = res_reg;

    // divider only runs on a real trial: divisor at least two, remainder at least two
    `SPF_ASSERT_IMP(a_div_operands, clk, rst_n, ucw.div_step, (div_reg >= DW'(2)) && (rem_reg >= DW'(2)), "divider stepping with bad operands")

    // taking a factor always shrinks the remainder
    `SPF_ASSERT_NXT(a_rem_shrinks, clk, rst_n, ucw.take_factor && div_sts.rem_zero, rem_reg < $past(rem_reg), "remainder did not shrink")

    // finishing step hands the clamped sum to the output register
    `SPF_ASSERT_NXT(a_out_load, clk, rst_n, ucw.ld_out && out_free, out_valid_reg && (factor_sum == $past(sum_sat)), "result not loaded")

endmodule
